FILE: design/rbvs_pkg.sv
package rbvs_pkg;

	localparam int NUM_BONES = 256;
	localparam int FRAC_BITS = 16;
	localparam int NUM_ELEMS = 12;
	localparam int NUM_COLS  = 3;
	localparam int DATA_W    = 32;
	localparam int BONE_W    = $clog2(NUM_BONES);
	localparam int ELEM_W    = 4;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 2;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef word_t [NUM_ELEMS-1:0] mat_t;

	localparam word_t FIX_ONE = DATA_W'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic              op;
		logic [7:0]        bone_index;
		logic [ELEM_W-1:0] element_index;
		word_t             element_value;
		word_t             pos_x;
		word_t             pos_y;
		word_t             pos_z;
		word_t             nrm_x;
		word_t             nrm_y;
		word_t             nrm_z;
		logic              last_vertex;
	} in_item_t;

	typedef struct packed {
		word_t out_pos_x;
		word_t out_pos_y;
		word_t out_pos_z;
		word_t out_nrm_x;
		word_t out_nrm_y;
		word_t out_nrm_z;
		logic  batch_end;
	} out_item_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

FILE: design/rigid_bone_vertex_skinning.sv
// A vertex item passes the input and palette-read registers, the product, sum and
// result registers; a load item writes the palette when accepted and gives no result.
// Throughput: one item per cycle through four stages of eighteen multipliers and
// twelve parallel palette banks; a stage stalls only while full and blocked downstream.
// Reset clears the pipeline valid bits and sets skinning on; the palette
// is not cleared and holds unknown data until loaded.
module rigid_bone_vertex_skinning (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rbvs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rbvs_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);

	logic                skin_enable_q;
	logic                v_s1, v_s2, v_s3, v_s4;
	logic                rdy1, rdy2, rdy3, rdy4;
	logic                in_fire, load_we, vtx_fire;
	rbvs_pkg::stage_en_t en;
	rbvs_pkg::mat_t      pal_data, mat;
	rbvs_pkg::word_t     px_s1, py_s1, pz_s1, nx_s1, ny_s1, nz_s1;
	logic                skin_s1;
	logic                last_s1, last_s2, last_s3, last_s4;
	rbvs_pkg::word_t     pos_res [rbvs_pkg::NUM_COLS];
	rbvs_pkg::word_t     nrm_res [rbvs_pkg::NUM_COLS];

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign in_fire  = in_valid && in_ready;
	assign load_we  = in_fire && (in_data.op == rbvs_pkg::OP_LOAD);
	assign vtx_fire = in_fire && (in_data.op == rbvs_pkg::OP_VERTEX);

	assign en.s2 = rdy2 && v_s1;
	assign en.s3 = rdy3 && v_s2;
	assign en.s4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skin_enable_q <= 1'b1;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
		end else begin
			if (cfg_we) begin
				skin_enable_q <= cfg_wdata;
			end
			if (rdy1) begin
				v_s1 <= vtx_fire;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_fire) begin
			px_s1   <= in_data.pos_x;
			py_s1   <= in_data.pos_y;
			pz_s1   <= in_data.pos_z;
			nx_s1   <= in_data.nrm_x;
			ny_s1   <= in_data.nrm_y;
			nz_s1   <= in_data.nrm_z;
			skin_s1 <= skin_enable_q;
			last_s1 <= in_data.last_vertex;
		end
		if (en.s2) begin
			last_s2 <= last_s1;
		end
		if (en.s3) begin
			last_s3 <= last_s2;
		end
		if (en.s4) begin
			last_s4 <= last_s3;
		end
	end

	rbvs_palette u_palette (
		.clk     (clk),
		.we      (load_we),
		.wr_bone (in_data.bone_index[rbvs_pkg::BONE_W-1:0]),
		.wr_elem (in_data.element_index),
		.wr_data (in_data.element_value),
		.rd_en   (vtx_fire),
		.rd_bone (in_data.bone_index[rbvs_pkg::BONE_W-1:0]),
		.rd_data (pal_data)
	);

	// With skinning off, the identity matrix passes the vertex through exactly.
	always_comb begin
		for (int i = 0; i < rbvs_pkg::NUM_ELEMS; i++) begin
			if (skin_s1) begin
				mat[i] = pal_data[i];
			end else if (i == 0 || i == 4 || i == 8) begin
				mat[i] = rbvs_pkg::FIX_ONE;
			end else begin
				mat[i] = '0;
			end
		end
	end

	for (genvar j = 0; j < rbvs_pkg::NUM_COLS; j++) begin : g_col
		rbvs_column u_pos (
			.clk (clk),
			.en  (en),
			.x   (px_s1),
			.y   (py_s1),
			.z   (pz_s1),
			.a   (mat[j]),
			.b   (mat[3 + j]),
			.c   (mat[6 + j]),
			.t   (mat[9 + j]),
			.res (pos_res[j])
		);

		rbvs_column u_nrm (
			.clk (clk),
			.en  (en),
			.x   (nx_s1),
			.y   (ny_s1),
			.z   (nz_s1),
			.a   (mat[j]),
			.b   (mat[3 + j]),
			.c   (mat[6 + j]),
			.t   ('0),
			.res (nrm_res[j])
		);
	end

	assign out_valid          = v_s4;
	assign out_data.out_pos_x = pos_res[0];
	assign out_data.out_pos_y = pos_res[1];
	assign out_data.out_pos_z = pos_res[2];
	assign out_data.out_nrm_x = nrm_res[0];
	assign out_data.out_nrm_y = nrm_res[1];
	assign out_data.out_nrm_z = nrm_res[2];
	assign out_data.batch_end = last_s4;

endmodule

FILE: design/rbvs_palette.sv
module rbvs_palette (
	input  logic                       clk,
	input  logic                       we,
	input  logic [rbvs_pkg::BONE_W-1:0] wr_bone,
	input  logic [rbvs_pkg::ELEM_W-1:0] wr_elem,
	input  rbvs_pkg::word_t            wr_data,
	input  logic                       rd_en,
	input  logic [rbvs_pkg::BONE_W-1:0] rd_bone,
	output rbvs_pkg::mat_t             rd_data
);

	rbvs_pkg::word_t rd_s1 [rbvs_pkg::NUM_ELEMS];

	for (genvar g = 0; g < rbvs_pkg::NUM_ELEMS; g++) begin : g_bank
		rbvs_pkg::word_t mem [rbvs_pkg::NUM_BONES];

		always_ff @(posedge clk) begin
			if (we && (wr_elem == rbvs_pkg::ELEM_W'(g))) begin
				mem[wr_bone] <= wr_data;
			end
			if (rd_en) begin
				rd_s1[g] <= mem[rd_bone];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < rbvs_pkg::NUM_ELEMS; i++) begin
			rd_data[i] = rd_s1[i];
		end
	end

endmodule

FILE: design/rbvs_column.sv
module rbvs_column (
	input  logic                clk,
	input  rbvs_pkg::stage_en_t en,
	input  rbvs_pkg::word_t     x,
	input  rbvs_pkg::word_t     y,
	input  rbvs_pkg::word_t     z,
	input  rbvs_pkg::word_t     a,
	input  rbvs_pkg::word_t     b,
	input  rbvs_pkg::word_t     c,
	input  rbvs_pkg::word_t     t,
	output rbvs_pkg::word_t     res
);

	localparam int H_W = rbvs_pkg::SUM_W + 1;

	logic signed [rbvs_pkg::PROD_W-1:0] prod0, prod1, prod2;
	logic signed [rbvs_pkg::PROD_W-1:0] p0_s2, p1_s2, p2_s2;
	rbvs_pkg::word_t                    t_s2, t_s3, res_s4;
	logic signed [rbvs_pkg::SUM_W-1:0]  sum_s3;
	logic signed [H_W-1:0]              h;
	rbvs_pkg::word_t                    sat;

	assign prod0 = x * a;
	assign prod1 = y * b;
	assign prod2 = z * c;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p0_s2 <= prod0;
			p1_s2 <= prod1;
			p2_s2 <= prod2;
			t_s2  <= t;
		end
		if (en.s3) begin
			sum_s3 <= rbvs_pkg::SUM_W'(p0_s2) + rbvs_pkg::SUM_W'(p1_s2)
				+ rbvs_pkg::SUM_W'(p2_s2);
			t_s3   <= t_s2;
		end
		if (en.s4) begin
			res_s4 <= sat;
		end
	end

	// The arithmetic shift rounds the exact sum toward minus infinity.
	always_comb begin
		h = H_W'(sum_s3 >>> rbvs_pkg::FRAC_BITS) + H_W'(t_s3);
		if ((&h[H_W-1:rbvs_pkg::DATA_W-1]) || !(|h[H_W-1:rbvs_pkg::DATA_W-1])) begin
			sat = h[rbvs_pkg::DATA_W-1:0];
		end else if (h[H_W-1]) begin
			sat = {1'b1, {(rbvs_pkg::DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(rbvs_pkg::DATA_W-1){1'b1}}};
		end
	end

	assign res = res_s4;

endmodule
